// ===== rtl/core/dnwe_pkg.sv =====
// shared types and constants of the dns name wire encoder
package dnwe_pkg;

	localparam int unsigned NAME_MAX    = 255;
	localparam int unsigned LABEL_MAX   = 63;
	localparam logic [7:0]  DOT_CHAR    = 8'd46;
	localparam logic [7:0]  END_CHAR    = 8'd0;

	localparam logic        KIND_WRITE  = 1'b0;
	localparam logic        KIND_STATUS = 1'b1;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// work for the back end: up to two buffer writes, then an optional status
	typedef struct packed {
		logic [1:0] num_writes;
		logic       has_status;
		logic [7:0] w0_offset;
		logic [7:0] w0_data;
		logic [7:0] w1_offset;
		logic       ok;
		logic [7:0] wire_length;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

// ===== rtl/core/dnwe_if.sv =====
// channel interfaces: name characters in, buffer writes and status out
interface dnwe_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

interface dnwe_result_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] offset;
	logic [7:0] data;
	logic       ok;
	logic [7:0] wire_length;
	logic       last;

	modport source (output valid, output kind, output offset, output data,
		output ok, output wire_length, output last, input ready);
	modport sink (input valid, input kind, input offset, input data,
		input ok, input wire_length, input last, output ready);
endinterface

// ===== rtl/core/dns_name_wire_encoder.sv =====
// top level of the dns name wire encoder
//
// chars: one name character per transfer; a zero character ends the name,
//   '.' separates labels, any other byte is label content.
// results: buffer writes (kind 0, offset and data) and one status per name
//   (kind 1, ok and wire_length); last marks the final result of a character.
// a label character gives one write, a dot one length-octet write, the end of
//   a name up to two writes (length octet, root zero) and the status.
//   rejected names give no writes after the error and a status with ok 0.
// a character's job is registered in the job queue, and its results then in the output register.
// throughput: one character per cycle while the job queue is not full; the
//   result port moves one result per cycle while results.ready is high, so an end
//   of name gives up to three results and the four-entry job queue absorbs that.
// chars.ready drops only when the job queue is full.
// reset clears the label state, the queue and the output valid flag; a stalled
//   result stays on the port until taken while characters keep flowing in
//   until the queue fills.
module dns_name_wire_encoder (
	input  logic          clk,
	input  logic          arst_n,
	dnwe_char_if.sink     chars,
	dnwe_result_if.source results
);

	dnwe_pkg::queue_stat_t stat;
	dnwe_pkg::job_t        push_job;
	dnwe_pkg::job_t        head;
	logic                  push;
	logic                  pop;

	dnwe_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.stat   (stat),
		.push   (push),
		.job    (push_job)
	);

	dnwe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	dnwe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.stat    (stat),
		.pop     (pop),
		.results (results)
	);

endmodule

// ===== rtl/core/dnwe_front.sv =====
// front end: tracks label state per character and classifies it into a job
module dnwe_front (
	input  logic                 clk,
	input  logic                 arst_n,
	dnwe_char_if.sink            chars,
	input  dnwe_pkg::queue_stat_t stat,
	output logic                 push,
	output dnwe_pkg::job_t       job
);

	logic [7:0] label_start_q;
	logic [6:0] label_count_q;
	logic       failed_q;

	logic       take;
	logic       is_end;
	logic       is_dot;
	logic [6:0] count_inc;
	logic [9:0] need_len;
	logic       too_long;
	logic [7:0] next_pos;

	assign chars.ready = !stat.full;
	assign take        = chars.valid && chars.ready;
	assign is_end      = (chars.ch == dnwe_pkg::END_CHAR);
	assign is_dot      = (chars.ch == dnwe_pkg::DOT_CHAR);
	assign count_inc   = label_count_q + 7'd1;
	// length octet, label so far plus this char, and the root octet
	assign need_len    = {2'b00, label_start_q} + {3'b000, count_inc} + 10'd2;
	assign too_long    = ({25'd0, count_inc} > dnwe_pkg::LABEL_MAX[31:0])
		|| ({22'd0, need_len} > dnwe_pkg::NAME_MAX[31:0]);
	assign next_pos    = label_start_q + 8'd1 + {1'b0, label_count_q};

	always_comb begin
		push            = 1'b0;
		job.num_writes  = 2'd0;
		job.has_status  = 1'b0;
		job.w0_offset   = label_start_q;
		job.w0_data     = {1'b0, label_count_q};
		job.w1_offset   = next_pos;
		job.ok          = 1'b0;
		job.wire_length = 8'd0;
		if (is_end) begin
			push           = take;
			job.has_status = 1'b1;
			if (!failed_q && label_count_q != 7'd0) begin
				job.num_writes  = 2'd2;
				job.ok          = 1'b1;
				job.wire_length = next_pos + 8'd1;
			end else if (!failed_q && label_start_q != 8'd0) begin
				// trailing dot: root octet sits where the next label would start
				job.num_writes  = 2'd1;
				job.w0_data     = 8'd0;
				job.ok          = 1'b1;
				job.wire_length = label_start_q + 8'd1;
			end
		end else if (!failed_q) begin
			if (is_dot) begin
				if (label_count_q != 7'd0) begin
					push           = take;
					job.num_writes = 2'd1;
				end
			end else if (!too_long) begin
				push           = take;
				job.num_writes = 2'd1;
				job.w0_offset  = next_pos;
				job.w0_data    = chars.ch;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_start_q <= 8'd0;
			label_count_q <= 7'd0;
			failed_q      <= 1'b0;
		end else if (take) begin
			if (is_end) begin
				label_start_q <= 8'd0;
				label_count_q <= 7'd0;
				failed_q      <= 1'b0;
			end else if (!failed_q) begin
				if (is_dot) begin
					if (label_count_q == 7'd0) begin
						failed_q <= 1'b1;
					end else begin
						label_start_q <= next_pos;
						label_count_q <= 7'd0;
					end
				end else if (too_long) begin
					failed_q <= 1'b1;
				end else begin
					label_count_q <= count_inc;
				end
			end
		end
	end

endmodule

// ===== rtl/core/dnwe_queue.sv =====
// short job queue between front and back end
module dnwe_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dnwe_pkg::job_t        push_job,
	input  logic                  pop,
	output dnwe_pkg::job_t        head,
	output dnwe_pkg::queue_stat_t stat
);

	dnwe_pkg::job_t                entry_q [dnwe_pkg::QUEUE_DEPTH];
	logic [dnwe_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [dnwe_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [dnwe_pkg::QUEUE_AW:0]   fill_q;

	assign head       = entry_q[rd_ptr_q];
	assign stat.full  = (fill_q == dnwe_pkg::QUEUE_DEPTH[dnwe_pkg::QUEUE_AW:0]);
	assign stat.empty = (fill_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/dnwe_back.sv =====
// back end: steps through the results of each job into the output register
module dnwe_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dnwe_pkg::job_t        head,
	input  dnwe_pkg::queue_stat_t stat,
	output logic                  pop,
	dnwe_result_if.source         results
);

	logic [1:0] idx_q;
	logic [1:0] total;
	logic       load;
	logic       is_last;
	logic       is_write;

	logic       valid_q;
	logic       kind_q;
	logic [7:0] offset_q;
	logic [7:0] data_q;
	logic       ok_q;
	logic [7:0] wire_length_q;
	logic       last_q;

	assign total    = head.num_writes + {1'b0, head.has_status};
	assign is_last  = (idx_q == total - 2'd1);
	assign is_write = (idx_q < head.num_writes);
	assign load     = !stat.empty && (!valid_q || results.ready);
	assign pop      = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (results.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= is_last;
			if (is_write) begin
				kind_q        <= dnwe_pkg::KIND_WRITE;
				offset_q      <= (idx_q == 2'd0) ? head.w0_offset : head.w1_offset;
				data_q        <= (idx_q == 2'd0) ? head.w0_data : 8'd0;
				ok_q          <= 1'b0;
				wire_length_q <= 8'd0;
			end else begin
				kind_q        <= dnwe_pkg::KIND_STATUS;
				offset_q      <= 8'd0;
				data_q        <= 8'd0;
				ok_q          <= head.ok;
				wire_length_q <= head.wire_length;
			end
		end
	end

	assign results.valid       = valid_q;
	assign results.kind        = kind_q;
	assign results.offset      = offset_q;
	assign results.data        = data_q;
	assign results.ok          = ok_q;
	assign results.wire_length = wire_length_q;
	assign results.last        = last_q;

endmodule
